>>> hdl/sc2a_pkg.sv
// shared types, key codes and layout tables for the scancode decoder
package sc2a_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [6:0] KEY_LSHIFT = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT = 7'h36;
   localparam logic [6:0] KEY_LCTRL  = 7'h1D;
   localparam logic [6:0] KEY_BKSP   = 7'h0E;
   localparam logic [6:0] KEY_UP     = 7'h48;
   localparam logic [6:0] KEY_DOWN   = 7'h50;
   localparam logic [6:0] KEY_LEFT   = 7'h4B;
   localparam logic [6:0] KEY_RIGHT  = 7'h4D;

   localparam logic [6:0] CHAR_NONE    = 7'h00;
   localparam logic [6:0] CHAR_ESC     = 7'h1B;
   localparam logic [6:0] CHAR_BRACKET = 7'h5B;
   localparam logic [6:0] CHAR_BS      = 7'h08;
   localparam logic [6:0] CHAR_DC3     = 7'h13;
   localparam logic [6:0] CHAR_DC1     = 7'h11;
   localparam logic [6:0] CHAR_UP      = 7'h41;
   localparam logic [6:0] CHAR_DOWN    = 7'h42;
   localparam logic [6:0] CHAR_RIGHT   = 7'h43;
   localparam logic [6:0] CHAR_LEFT    = 7'h44;
   localparam logic [6:0] CHAR_S_LOWER = 7'h73;
   localparam logic [6:0] CHAR_S_UPPER = 7'h53;
   localparam logic [6:0] CHAR_Q_LOWER = 7'h71;
   localparam logic [6:0] CHAR_Q_UPPER = 7'h51;

   // one queued action: a single character, or an arrow escape run ending in ch
   typedef struct packed {
      logic       arrow;
      logic [6:0] ch;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BEAT_FIRST,
      BEAT_SECOND,
      BEAT_THIRD
   } back_beat_type;

   function automatic logic [6:0] plain_char(input logic [6:0] code);
      logic [7:0] c;
      c = 8'h00;
      case (code)
         7'h02: c = "1";
         7'h03: c = "2";
         7'h04: c = "3";
         7'h05: c = "4";
         7'h06: c = "5";
         7'h07: c = "6";
         7'h08: c = "7";
         7'h09: c = "8";
         7'h0A: c = "9";
         7'h0B: c = "0";
         7'h0C: c = "-";
         7'h0D: c = "=";
         7'h0F: c = "\t";
         7'h10: c = "q";
         7'h11: c = "w";
         7'h12: c = "e";
         7'h13: c = "r";
         7'h14: c = "t";
         7'h15: c = "y";
         7'h16: c = "u";
         7'h17: c = "i";
         7'h18: c = "o";
         7'h19: c = "p";
         7'h1A: c = "[";
         7'h1B: c = "]";
         7'h1C: c = "\n";
         7'h1E: c = "a";
         7'h1F: c = "s";
         7'h20: c = "d";
         7'h21: c = "f";
         7'h22: c = "g";
         7'h23: c = "h";
         7'h24: c = "j";
         7'h25: c = "k";
         7'h26: c = "l";
         7'h27: c = ";";
         7'h28: c = "'";
         7'h29: c = "#";
         7'h2B: c = "\\";
         7'h2C: c = "z";
         7'h2D: c = "x";
         7'h2E: c = "c";
         7'h2F: c = "v";
         7'h30: c = "b";
         7'h31: c = "n";
         7'h32: c = "m";
         7'h33: c = ",";
         7'h34: c = ".";
         7'h35: c = "/";
         7'h37: c = "*";
         7'h39: c = " ";
         default: c = 8'h00;
      endcase
      return c[6:0];
   endfunction

   function automatic logic [6:0] shift_char(input logic [6:0] code);
      logic [7:0] c;
      c = 8'h00;
      case (code)
         7'h02: c = "!";
         7'h03: c = "\"";
         7'h04: c = "#";
         7'h05: c = "$";
         7'h06: c = "%";
         7'h07: c = "^";
         7'h08: c = "&";
         7'h09: c = "*";
         7'h0A: c = "(";
         7'h0B: c = ")";
         7'h0C: c = "_";
         7'h0D: c = "+";
         7'h0F: c = "\t";
         7'h10: c = "Q";
         7'h11: c = "W";
         7'h12: c = "E";
         7'h13: c = "R";
         7'h14: c = "T";
         7'h15: c = "Y";
         7'h16: c = "U";
         7'h17: c = "I";
         7'h18: c = "O";
         7'h19: c = "P";
         7'h1A: c = "{";
         7'h1B: c = "}";
         7'h1C: c = "\n";
         7'h1E: c = "A";
         7'h1F: c = "S";
         7'h20: c = "D";
         7'h21: c = "F";
         7'h22: c = "G";
         7'h23: c = "H";
         7'h24: c = "J";
         7'h25: c = "K";
         7'h26: c = "L";
         7'h27: c = ":";
         7'h28: c = "@";
         7'h29: c = "~";
         7'h2B: c = "|";
         7'h2C: c = "Z";
         7'h2D: c = "X";
         7'h2E: c = "C";
         7'h2F: c = "V";
         7'h30: c = "B";
         7'h31: c = "N";
         7'h32: c = "M";
         7'h33: c = "<";
         7'h34: c = ">";
         7'h35: c = "?";
         7'h37: c = "*";
         7'h39: c = " ";
         default: c = 8'h00;
      endcase
      return c[6:0];
   endfunction

endpackage

>>> hdl/sc2a_front.sv
// front end: accepts scancode bytes, tracks modifier state and classifies each key
module sc2a_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_scan_byte,
   input  sc2a_pkg::queue_status_type q_status,
   output sc2a_pkg::queue_push_type   q_push
);
   import sc2a_pkg::*;

   logic       shift_ff, shift_in;
   logic       ctrl_ff, ctrl_in;
   logic [7:0] prev_ff, prev_in;
   logic       accept;
   logic       release_key;
   logic [6:0] code;
   logic [6:0] looked_up;

   assign req_stall   = q_status.full;
   assign accept      = req_valid && !q_status.full;
   assign release_key = req_scan_byte[7];
   assign code        = req_scan_byte[6:0];
   assign looked_up   = shift_ff ? shift_char(code) : plain_char(code);

   always_comb begin
      shift_in  = shift_ff;
      ctrl_in   = ctrl_ff;
      prev_in   = prev_ff;
      q_push    = '0;
      if (accept) begin
         if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
            shift_in = !release_key;
         end else if (code == KEY_LCTRL) begin
            ctrl_in = !release_key;
         end else if (release_key) begin
            prev_in = 8'h00;
         end else if (req_scan_byte != prev_ff) begin
            prev_in = req_scan_byte;
            case (code)
               KEY_UP: begin
                  q_push = '{valid: 1'b1, entry: '{arrow: 1'b1, ch: CHAR_UP}};
               end
               KEY_DOWN: begin
                  q_push = '{valid: 1'b1, entry: '{arrow: 1'b1, ch: CHAR_DOWN}};
               end
               KEY_RIGHT: begin
                  q_push = '{valid: 1'b1, entry: '{arrow: 1'b1, ch: CHAR_RIGHT}};
               end
               KEY_LEFT: begin
                  q_push = '{valid: 1'b1, entry: '{arrow: 1'b1, ch: CHAR_LEFT}};
               end
               KEY_BKSP: begin
                  q_push = '{valid: 1'b1, entry: '{arrow: 1'b0, ch: CHAR_BS}};
               end
               default: begin
                  if (ctrl_ff) begin
                     // only s and q mean anything with ctrl held
                     if (looked_up == CHAR_S_LOWER || looked_up == CHAR_S_UPPER) begin
                        q_push = '{valid: 1'b1, entry: '{arrow: 1'b0, ch: CHAR_DC3}};
                     end else if (looked_up == CHAR_Q_LOWER || looked_up == CHAR_Q_UPPER) begin
                        q_push = '{valid: 1'b1, entry: '{arrow: 1'b0, ch: CHAR_DC1}};
                     end
                  end else if (looked_up != CHAR_NONE) begin
                     q_push = '{valid: 1'b1, entry: '{arrow: 1'b0, ch: looked_up}};
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         prev_ff  <= 8'h00;
      end else begin
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

>>> hdl/sc2a_queue.sv
// short action queue between the front and back ends
module sc2a_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  sc2a_pkg::queue_push_type   q_push,
   input  logic                       q_pop,
   output sc2a_pkg::queue_status_type q_status,
   output sc2a_pkg::queue_entry_type  q_head
);
   import sc2a_pkg::*;

   queue_entry_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                      do_pop;

   assign q_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_head         = slot_ff[rd_ptr_ff];
   assign do_pop         = q_pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({q_push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         slot_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

>>> hdl/sc2a_back.sv
// back end: expands queued actions into characters and holds the result register
module sc2a_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sc2a_pkg::queue_status_type q_status,
   input  sc2a_pkg::queue_entry_type  q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [6:0]                 rsp_character,
   output logic                       rsp_last_of_run
);
   import sc2a_pkg::*;

   back_beat_type beat_ff, beat_in;
   logic          valid_ff, valid_in;
   logic [6:0]    char_ff, char_in;
   logic          last_ff, last_in;
   logic          load;

   assign load            = !valid_ff || !rsp_stall;
   assign rsp_valid       = valid_ff;
   assign rsp_character   = char_ff;
   assign rsp_last_of_run = last_ff;

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (q_head.arrow) begin
               // escape, bracket, then the direction letter
               unique case (beat_ff)
                  BEAT_FIRST: begin
                     char_in = CHAR_ESC;
                     last_in = 1'b0;
                     beat_in = BEAT_SECOND;
                  end
                  BEAT_SECOND: begin
                     char_in = CHAR_BRACKET;
                     last_in = 1'b0;
                     beat_in = BEAT_THIRD;
                  end
                  BEAT_THIRD: begin
                     char_in = q_head.ch;
                     last_in = 1'b1;
                     beat_in = BEAT_FIRST;
                     q_pop   = 1'b1;
                  end
                  default: begin
                     beat_in = BEAT_FIRST;
                  end
               endcase
            end else begin
               char_in = q_head.ch;
               last_in = 1'b1;
               q_pop   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= BEAT_FIRST;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

>>> hdl/scancode_to_ascii_decoder_top.sv
// set-1 scancode to ascii decoder: top level
// the first character of a byte goes through the action queue and then the
// result register before it shows on rsp_*
// throughput: one byte per cycle in unless the queue is full; one character per cycle
// out unless rsp_stall is high; an arrow key yields three characters, a plain key one
// the two-entry action queue decides when req_stall rises
// synchronous reset clears shift, ctrl, last make code, queue and result valid
module scancode_to_ascii_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_character,
   output logic       rsp_last_of_run
);
   import sc2a_pkg::*;

   queue_push_type   q_push;
   queue_status_type q_status;
   queue_entry_type  q_head;
   logic             q_pop;

   sc2a_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_scan_byte (req_scan_byte),
      .q_status      (q_status),
      .q_push        (q_push)
   );

   sc2a_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status),
      .q_head   (q_head)
   );

   sc2a_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_character   (rsp_character),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> hdl/sc2a_checker.sv
// port-level checks for the scancode decoder, bound to the top level
module sc2a_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_scan_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_character,
   input logic       rsp_last_of_run
);
   import sc2a_pkg::*;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character)
                                 && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // only the escape and bracket of an arrow run are not last
   a_not_last_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_character == CHAR_ESC
                                        || rsp_character == CHAR_BRACKET)
      else $error("unexpected non-final character");

   // escape is followed straight away by the bracket
   a_esc_then_bracket: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_character == CHAR_ESC && !rsp_last_of_run
      |=> rsp_valid && rsp_character == CHAR_BRACKET && !rsp_last_of_run)
      else $error("escape not followed by bracket");

   // bracket is followed straight away by the direction letter
   a_bracket_then_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_character == CHAR_BRACKET && !rsp_last_of_run
      |=> rsp_valid && rsp_last_of_run
          && (rsp_character == CHAR_UP || rsp_character == CHAR_DOWN
              || rsp_character == CHAR_RIGHT || rsp_character == CHAR_LEFT))
      else $error("bracket not followed by direction letter");

endmodule

bind scancode_to_ascii_decoder_top sc2a_checker u_sc2a_checker (.*);

>>> bench/sc2a_tb_pkg.sv
// keymap tables and character scoreboard for the scancode decoder bench
package sc2a_tb_pkg;

   import sc2a_pkg::*;

   // uk layout, indexed by key code; codes past the end map to nothing
   localparam int MAP_SIZE = 58;

   localparam logic [7:0] PLAIN_MAP [0:MAP_SIZE-1] = '{
      8'h00, 8'h00, "1",   "2",   "3",   "4",   "5",   "6",
      "7",   "8",   "9",   "0",   "-",   "=",   8'h00, "\t",
      "q",   "w",   "e",   "r",   "t",   "y",   "u",   "i",
      "o",   "p",   "[",   "]",   "\n",  8'h00, "a",   "s",
      "d",   "f",   "g",   "h",   "j",   "k",   "l",   ";",
      "'",   "#",   8'h00, "\\",  "z",   "x",   "c",   "v",
      "b",   "n",   "m",   ",",   ".",   "/",   8'h00, "*",
      8'h00, " "
   };

   localparam logic [7:0] SHIFT_MAP [0:MAP_SIZE-1] = '{
      8'h00, 8'h00, "!",   "\"",  "#",   "$",   "%",   "^",
      "&",   "*",   "(",   ")",   "_",   "+",   8'h00, "\t",
      "Q",   "W",   "E",   "R",   "T",   "Y",   "U",   "I",
      "O",   "P",   "{",   "}",   "\n",  8'h00, "A",   "S",
      "D",   "F",   "G",   "H",   "J",   "K",   "L",   ":",
      "@",   "~",   8'h00, "|",   "Z",   "X",   "C",   "V",
      "B",   "N",   "M",   "<",   ">",   "?",   8'h00, "*",
      8'h00, " "
   };

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } char_beat_type;

   class keystroke_scoreboard;
      char_beat_type pending_chars[$];
      bit            shift_on;
      bit            ctrl_on;
      logic [7:0]    prev_make_byte;
      int            errors;

      function new();
         shift_on       = 1'b0;
         ctrl_on        = 1'b0;
         prev_make_byte = 8'h00;
         errors         = 0;
      endfunction

      function logic [6:0] layout_char(input bit shifted, input logic [6:0] code);
         if (code >= MAP_SIZE)
            return CHAR_NONE;
         return shifted ? SHIFT_MAP[code][6:0] : PLAIN_MAP[code][6:0];
      endfunction

      function void push_char(input logic [6:0] ch, input logic last);
         char_beat_type beat;
         beat.ch   = ch;
         beat.last = last;
         pending_chars.push_back(beat);
      endfunction

      // works out the characters caused by one accepted scancode byte
      function void note_scan(input logic [7:0] scan);
         logic       rel;
         logic [6:0] code;
         logic [6:0] ch;
         rel  = scan[7];
         code = scan[6:0];
         if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
            shift_on = !rel;
            return;
         end
         if (code == KEY_LCTRL) begin
            ctrl_on = !rel;
            return;
         end
         if (rel) begin
            prev_make_byte = 8'h00;
            return;
         end
         if (scan == prev_make_byte)
            return;
         prev_make_byte = scan;
         if (code == KEY_UP || code == KEY_DOWN || code == KEY_RIGHT || code == KEY_LEFT) begin
            push_char(CHAR_ESC, 1'b0);
            push_char(CHAR_BRACKET, 1'b0);
            case (code)
               KEY_UP:    push_char(CHAR_UP, 1'b1);
               KEY_DOWN:  push_char(CHAR_DOWN, 1'b1);
               KEY_RIGHT: push_char(CHAR_RIGHT, 1'b1);
               default:   push_char(CHAR_LEFT, 1'b1);
            endcase
            return;
         end
         if (code == KEY_BKSP) begin
            push_char(CHAR_BS, 1'b1);
            return;
         end
         ch = layout_char(shift_on, code);
         if (ctrl_on) begin
            if (ch == CHAR_S_LOWER || ch == CHAR_S_UPPER)
               push_char(CHAR_DC3, 1'b1);
            else if (ch == CHAR_Q_LOWER || ch == CHAR_Q_UPPER)
               push_char(CHAR_DC1, 1'b1);
            return;
         end
         if (ch != CHAR_NONE)
            push_char(ch, 1'b1);
      endfunction

      task report(input string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_char(input logic [6:0] ch, input logic last);
         char_beat_type want;
         if (pending_chars.size() == 0) begin
            report($sformatf("unexpected character %h last %b", ch, last));
            return;
         end
         want = pending_chars.pop_front();
         if (ch !== want.ch)
            report($sformatf("character %h, expected %h", ch, want.ch));
         if (last !== want.last)
            report($sformatf("last_of_run %b, expected %b (char %h)", last, want.last, want.ch));
      endtask
   endclass

endpackage

>>> bench/scancode_to_ascii_decoder_top_tb.sv
// bench for the scancode decoder: directed and random scancodes, checked per character
module scancode_to_ascii_decoder_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import sc2a_pkg::*;
   import sc2a_tb_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_scan_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [6:0] rsp_character;
   logic       rsp_last_of_run;

   keystroke_scoreboard sb = new();

   bit         sender_busy = 1'b1;
   bit         recv_busy = 1'b1;
   bit         long_hold = 1'b0;
   int         sent_count = 0;
   int         recv_count = 0;

   // generator bookkeeping only, not used for prediction
   logic [6:0] held_key = 7'h10;
   bit         shift_gen = 1'b0;
   bit         ctrl_gen = 1'b0;

   scancode_to_ascii_decoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_scan_byte   (req_scan_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_character   (rsp_character),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int pick_gap();
      return sender_busy ? $urandom_range(0, 16) : 0;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_scan(input logic [7:0] scan, input int gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_scan_byte = scan;
      do @(posedge clock); while (req_stall);
      sb.note_scan(scan);
      sent_count++;
      @(negedge clock);
   endtask

   // mostly keyboard-like press/release runs, with some raw noise
   function automatic logic [7:0] next_random_scan();
      int r;
      logic [6:0] code;
      if (ctrl_gen && $urandom_range(0, 3) == 0) begin
         ctrl_gen = 1'b0;
         return {1'b1, KEY_LCTRL};
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0:       code = KEY_UP;
               1:       code = KEY_DOWN;
               2:       code = KEY_LEFT;
               default: code = KEY_RIGHT;
            endcase
         end else if ($urandom_range(0, 9) == 0) begin
            code = 7'($urandom_range(0, 127));
         end else begin
            code = 7'($urandom_range(1, 8'h3A));
         end
         held_key = code;
         return {1'b0, code};
      end
      if (r < 70)
         return {1'b1, held_key};
      if (r < 78) begin
         code = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
         shift_gen = !shift_gen;
         return {!shift_gen, code};
      end
      if (r < 82) begin
         ctrl_gen = 1'b1;
         return {1'b0, KEY_LCTRL};
      end
      if (r < 90)
         return {1'b0, held_key};
      return 8'($urandom_range(0, 255));
   endfunction

   // receiver: random hold-off per character, plus the long hold when asked
   initial begin
      int hold;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         hold = recv_busy ? $urandom_range(0, 16) : 0;
         repeat (hold) begin
            rsp_stall = 1'b1;
            @(negedge clock);
         end
         forever begin
            rsp_stall = long_hold;
            @(posedge clock);
            if (rsp_valid && !rsp_stall)
               break;
            @(negedge clock);
         end
         sb.check_char(rsp_character, rsp_last_of_run);
         recv_count++;
         if (recv_count % 30 == 0)
            recv_busy = !recv_busy;
         @(negedge clock);
      end
   end

   // long stall on the result side so the queue fills and the input stalls
   initial begin
      @(posedge clock);
      while (sent_count < 60) @(posedge clock);
      long_hold = 1'b1;
      repeat (300) @(posedge clock);
      long_hold = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [7:0] directed[$];
      directed = '{
         8'h00, 8'h7F, 8'h7F, 8'hFF, 8'h80, 8'h02, 8'h39,
         8'h48, 8'h50, 8'h4D, 8'h4B, 8'h4B, 8'hCB, 8'h0E,
         8'h2A, 8'h1E, 8'h0D, 8'hAA, 8'h1D, 8'h1F, 8'h10,
         8'h1E, 8'h36, 8'h1F, 8'h9D, 8'hB6, 8'h3B
      };
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_scan_byte = 8'h00;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_scan(directed[i], pick_gap());

      for (int i = 0; i < 300; i++) begin
         if (i % 40 == 0)
            sender_busy = !sender_busy;
         send_scan(next_random_scan(), pick_gap());
      end
      req_valid = 1'b0;

      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
